// File: design/sem_pkg.sv
package sem_pkg;

  localparam int unsigned PIXEL_W          = 8;
  localparam int unsigned MAG_W            = 8;
  localparam int unsigned CFG_W            = 11;
  localparam int unsigned LINE_WIDTH_RESET = 640;
  localparam int unsigned MIN_LINE_WIDTH   = 3;
  localparam int unsigned GRAD_W           = PIXEL_W + 2;
  localparam int unsigned SQ_W             = 2 * GRAD_W;
  localparam int unsigned SUM_W            = SQ_W + 1;
  localparam int unsigned ROOT_IN_W        = 2 * MAG_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_GRAD = 7'b0000100,
    ST_SQR  = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_ROOT = 7'b0100000,
    ST_OUT  = 7'b1000000
  } sem_state_e;

endpackage

// File: design/sem_pix_if.sv
interface sem_pix_if;
  import sem_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// File: design/sem_res_if.sv
interface sem_res_if #(
  parameter int unsigned COL_W = 10,
  parameter int unsigned ROW_W = 12
);
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic [COL_W-1:0] center_column;
  logic [ROW_W-1:0] center_row;

  modport source (output valid, output magnitude, output center_column,
                  output center_row, input ready);
  modport sink   (input valid, input magnitude, input center_column,
                  input center_row, output ready);
endinterface

// File: design/sem_ram.sv
module sem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sobel_edge_magnitude_3x3.sv
// 3x3 Sobel gradient magnitude over a raster stream of 8-bit grey pixels.
// pix_i takes one pixel per item with a frame-start mark on column 0, row 0.
// res_o gives, for every interior pixel, floor(sqrt(gx^2 + gy^2)) saturated
// at 255 with the column and row of the centre pixel, one row and one
// column behind the pixel that completes its window. Border pixels give no
// result. cfg_we_i/cfg_data_i write line_width (pixels per row, used within
// 3..MAX_WIDTH); write it only while the block is idle.
// One item is in work at a time. Each item reads both line stores at its
// column (registered RAM read) and writes them back in the next cycle, after
// which a border pixel is done. An interior pixel then goes through gradient,
// square and sum stages and an 8-step bit-serial square root (skipped when
// it saturates) into the output register, and the block returns to idle
// before it takes the next item.
// The output register parts the two sides: while a result waits to be
// taken, the block keeps accepting items and stalls only when a new result
// is ready for a still-full output register.
// Reset clears the counters and the window and sets line_width to 640; line store
// contents are undefined until written and need no clearing pass.
module sobel_edge_magnitude_3x3 #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [sem_pkg::CFG_W-1:0] cfg_data_i,
  sem_pix_if.sink                  pix_i,
  sem_res_if.source                res_o
);
  import sem_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W  = (CFG_W > WCNT_W) ? CFG_W : WCNT_W;

  sem_state_e state_q, state_d;

  logic [CFG_W-1:0]   line_width_q;
  logic [COL_W-1:0]   col_cnt_q;
  logic [ROW_W-1:0]   row_cnt_q;
  logic [PIXEL_W-1:0] win_q [9];

  logic [PIXEL_W-1:0] pix_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic               emit_q;
  logic [GRAD_W-1:0]  abs_gx_q, abs_gy_q;
  logic [SQ_W-1:0]    sq_x_q, sq_y_q;
  logic [ROOT_IN_W-1:0] sum_q;
  logic [MAG_W-1:0]   root_q, bit_q;

  logic               res_valid_q;
  logic [MAG_W-1:0]   mag_q;
  logic [COL_W-1:0]   ccol_q;
  logic [ROW_W-1:0]   crow_q;

  // Column and row bookkeeping for the item on the input
  logic [CMP_W-1:0]   lw_ext, width;
  logic [COL_W-1:0]   col_base, col_eff, col_next;
  logic [ROW_W-1:0]   row_base, row_next;
  logic               row_last;
  logic               accept;

  assign lw_ext = CMP_W'(line_width_q);

  always_comb begin
    if (lw_ext < CMP_W'(MIN_LINE_WIDTH)) begin
      width = CMP_W'(MIN_LINE_WIDTH);
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      width = CMP_W'(MAX_WIDTH);
    end else begin
      width = lw_ext;
    end
  end

  assign col_base = pix_i.frame_start ? '0 : col_cnt_q;
  assign row_base = pix_i.frame_start ? '0 : row_cnt_q;
  assign col_eff  = (CMP_W'(col_base) >= width) ? '0 : col_base;
  assign row_last = (CMP_W'(col_eff) + CMP_W'(1)) >= width;
  assign col_next = row_last ? '0 : col_eff + COL_W'(1);
  assign row_next = (row_last && (row_base != ROW_W'(MAX_HEIGHT - 1)))
                    ? row_base + ROW_W'(1) : row_base;

  assign pix_i.ready = (state_q == ST_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;

  // Line stores
  logic [PIXEL_W-1:0] upper_rd, middle_rd;
  logic               ls_we;

  assign ls_we = (state_q == ST_READ);

  sem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (col_q),
    .wdata_i (middle_rd),
    .raddr_i (col_eff),
    .rdata_o (upper_rd)
  );

  sem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (col_q),
    .wdata_i (pix_q),
    .raddr_i (col_eff),
    .rdata_o (middle_rd)
  );

  // Gradients from the registered window
  logic [GRAD_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;

  assign gx_pos = GRAD_W'(win_q[2]) + {1'b0, win_q[5], 1'b0} + GRAD_W'(win_q[8]);
  assign gx_neg = GRAD_W'(win_q[0]) + {1'b0, win_q[3], 1'b0} + GRAD_W'(win_q[6]);
  assign gy_pos = GRAD_W'(win_q[6]) + {1'b0, win_q[7], 1'b0} + GRAD_W'(win_q[8]);
  assign gy_neg = GRAD_W'(win_q[0]) + {1'b0, win_q[1], 1'b0} + GRAD_W'(win_q[2]);

  logic [SUM_W-1:0]     sum_full;
  logic [MAG_W-1:0]     trial;
  logic [ROOT_IN_W-1:0] trial_sq;
  logic                 out_free;

  assign sum_full = SUM_W'(sq_x_q) + SUM_W'(sq_y_q);
  assign trial    = root_q | bit_q;
  assign trial_sq = ROOT_IN_W'(trial) * ROOT_IN_W'(trial);
  assign out_free = !res_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = emit_q ? ST_GRAD : ST_IDLE;
      ST_GRAD: state_d = ST_SQR;
      ST_SQR:  state_d = ST_SUM;
      ST_SUM:  state_d = (sum_full[SUM_W-1:ROOT_IN_W] != '0) ? ST_OUT : ST_ROOT;
      ST_ROOT: if (bit_q[0]) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      line_width_q <= CFG_W'(LINE_WIDTH_RESET);
      col_cnt_q    <= '0;
      row_cnt_q    <= '0;
      res_valid_q  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        line_width_q <= cfg_data_i;
      end
      if (accept) begin
        col_cnt_q <= col_next;
        row_cnt_q <= row_next;
      end
      // Shift the window one column left and take the new right column
      if (state_q == ST_READ) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]     <= win_q[r*3 + 1];
          win_q[r*3 + 1] <= win_q[r*3 + 2];
        end
        win_q[2] <= upper_rd;
        win_q[5] <= middle_rd;
        win_q[8] <= pix_q;
      end
      if (state_q == ST_OUT && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= pix_i.pixel;
      col_q  <= col_eff;
      row_q  <= row_base;
      emit_q <= (col_eff >= COL_W'(2)) && (row_base >= ROW_W'(2));
    end
    if (state_q == ST_GRAD) begin
      abs_gx_q <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
      abs_gy_q <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    end
    if (state_q == ST_SQR) begin
      sq_x_q <= SQ_W'(abs_gx_q) * SQ_W'(abs_gx_q);
      sq_y_q <= SQ_W'(abs_gy_q) * SQ_W'(abs_gy_q);
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_full[ROOT_IN_W-1:0];
      bit_q <= {1'b1, {(MAG_W-1){1'b0}}};
      // Saturate: the root of anything past 16 bits is at least 256
      root_q <= (sum_full[SUM_W-1:ROOT_IN_W] != '0) ? '1 : '0;
    end
    if (state_q == ST_ROOT) begin
      if (trial_sq <= sum_q) begin
        root_q <= trial;
      end
      bit_q <= bit_q >> 1;
    end
    if (state_q == ST_OUT && out_free) begin
      mag_q  <= root_q;
      ccol_q <= col_q - COL_W'(1);
      crow_q <= row_q - ROW_W'(1);
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.magnitude     = mag_q;
  assign res_o.center_column = ccol_q;
  assign res_o.center_row    = crow_q;

endmodule

// File: design/sem_checker.sv
module sem_checker #(
  parameter int unsigned COL_W = 10,
  parameter int unsigned ROW_W = 12
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      pix_valid_i,
  input logic                      pix_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [sem_pkg::MAG_W-1:0] magnitude_i,
  input logic [COL_W-1:0]          center_column_i,
  input logic [ROW_W-1:0]          center_row_i
);
  import sem_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable({magnitude_i, center_column_i, center_row_i}))
    else $error("stalled result changed or dropped");

  // One item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i |=> !pix_ready_i)
    else $error("input taken while an item is in work");

  // A new result is loaded only from the final stage, never while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> !$past(pix_ready_i))
    else $error("result appeared while the block was idle");

  // Results belong to interior pixels only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (center_column_i != '0) && (center_row_i != '0))
    else $error("result for a border pixel");

endmodule

bind sobel_edge_magnitude_3x3 sem_checker #(.COL_W(COL_W), .ROW_W(ROW_W)) u_sem_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pix_valid_i     (pix_i.valid),
  .pix_ready_i     (pix_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .magnitude_i     (res_o.magnitude),
  .center_column_i (res_o.center_column),
  .center_row_i    (res_o.center_row)
);
